>>> design/nau_pkg.sv
// Shared types, constants and the sigmoid lookup table for the activation unit.
// Used by every module of the block; depends on nothing else.

package nau_pkg;

  // Number format
  localparam int FRACTION_BITS = 10;
  localparam int DATA_W        = 16;
  localparam int WIDE_W        = DATA_W + 4;
  localparam int VARG_W        = DATA_W + 1;

  // Sigmoid table geometry
  localparam int SIG_ENTRIES = 1024;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
  localparam int SIG_W       = FRACTION_BITS + 1;
  localparam int OFF_W       = FRACTION_BITS + 4;

  // Multiplier widths
  localparam int MUL_W  = SIG_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Leaky slope register and product
  localparam int LEAK_W      = 16;
  localparam int LEAK_PROD_W = DATA_W + LEAK_W + 1;
  localparam logic [LEAK_W-1:0] LEAK_RESET = LEAK_W'(655);

  // Configuration port
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_LEAK_SLOPE = 1'b0;

  // Useful constants
  localparam logic signed [WIDE_W-1:0] ONE_WIDE  = WIDE_W'(1 << FRACTION_BITS);
  localparam logic signed [WIDE_W-1:0] Y_MAX     = WIDE_W'(32767);
  localparam logic signed [WIDE_W-1:0] Y_MIN     = WIDE_W'(-32768);
  localparam logic signed [VARG_W-1:0] SIG_LO    = VARG_W'(-(8 << FRACTION_BITS));
  localparam logic signed [VARG_W-1:0] SIG_HI    = VARG_W'(8 << FRACTION_BITS);

  // Opcodes
  typedef enum logic [3:0] {
    OP_SIG    = 4'd0,
    OP_DSIG   = 4'd1,
    OP_G      = 4'd2,
    OP_DG     = 4'd3,
    OP_H      = 4'd4,
    OP_DH     = 4'd5,
    OP_ID     = 4'd6,
    OP_DID    = 4'd7,
    OP_RELU   = 4'd8,
    OP_DRELU  = 4'd9,
    OP_LEAKY  = 4'd10,
    OP_DLEAKY = 4'd11,
    OP_TANH   = 4'd12,
    OP_DTANH  = 4'd13,
    OP_CLIP   = 4'd14
  } op_t;

  // Control that travels down the pipeline with each request
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic signed [DATA_W-1:0] x;
  } nau_ctl_t;

  typedef logic [SIG_W-1:0] sig_tab_t [SIG_ENTRIES];

  // Restoring long division, used only while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at the midpoint of each table cell over [-8, 8), Q30 internally.
  // e^-|m| from a Taylor series of e^-(|m|/16), then squared four times.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t           tab;
    longint unsigned    num;
    longint             m;
    longint unsigned    a;
    longint unsigned    u;
    longint unsigned    term;
    longint             sum;
    longint unsigned    r;
    longint unsigned    s;
    longint unsigned    q30;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      q30 = 64'd1 << 30;
      num = (longint'(2 * i + 1) * 64'd8) << 30;
      m   = longint'(num >> SIG_IDX_W) - (longint'(8) << 30);
      a   = (m < 0) ? longint'(-m) : longint'(m);
      u   = a >> 4;
      term = q30;
      sum  = longint'(q30);
      for (int k = 1; k <= 16; k++) begin
        term = div_u64((term * u) >> 30, 64'(k));
        if (k[0] == 1'b1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      r = longint'(sum);
      for (int k = 0; k < 4; k++) begin
        r = (r * r + (q30 >> 1)) >> 30;
      end
      s = div_u64(64'd1 << 60, q30 + r);
      if (m < 0) s = q30 - s;
      tab[i] = SIG_W'((s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

>>> design/neural_activation_unit.sv
// Top level of the activation unit: register port and four-stage pipeline.
// Depends on nau_pkg, nau_front, nau_lookup, nau_mult and nau_final.
//
//   channel   ports                                   handshake
//   request   start, opcode, x_value                  taken when start && !busy
//   result    done, y_value                           one cycle, strobe done
//   config    psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//             prdata, pready
//
// One request per clock; busy is always low. Each request passes the stage
// registers in order: index, table read, multiplier, output.
// Reset clears the stage valid bits and sets leak_slope to 655.
// Results cannot be held off, so the pipeline never stalls.

module neural_activation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        opcode,
  input  logic signed [nau_pkg::DATA_W-1:0] x_value,
  output logic                              done,
  output logic signed [nau_pkg::DATA_W-1:0] y_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nau_pkg::ADDR_W-1:0]        paddr,
  input  logic [nau_pkg::PDATA_W-1:0]       pwdata,
  output logic [nau_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  logic [nau_pkg::LEAK_W-1:0]             leak_slope;
  logic                                   reg_sel;
  nau_pkg::nau_ctl_t                      ctl1;
  nau_pkg::nau_ctl_t                      ctl2;
  nau_pkg::nau_ctl_t                      ctl3;
  logic [nau_pkg::SIG_IDX_W-1:0]          idx1;
  logic signed [nau_pkg::LEAK_PROD_W-1:0] lprod1;
  logic [nau_pkg::SIG_W-1:0]              sig2;
  logic [nau_pkg::SIG_W-1:0]              sig3;
  logic signed [nau_pkg::VARG_W-1:0]      leaky2;
  logic signed [nau_pkg::VARG_W-1:0]      leaky3;
  logic signed [nau_pkg::PROD_W-1:0]      prod3;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register decode and readback
  assign reg_sel = (paddr[2] == nau_pkg::REG_LEAK_SLOPE);
  assign prdata  = reg_sel ? nau_pkg::PDATA_W'(leak_slope) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_slope <= nau_pkg::LEAK_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      leak_slope <= pwdata[nau_pkg::LEAK_W-1:0];
    end
  end

  nau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start && !busy),
    .opcode     (opcode),
    .x_value    (x_value),
    .leak_slope (leak_slope),
    .ctl        (ctl1),
    .idx        (idx1),
    .leak_prod  (lprod1)
  );

  nau_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl1),
    .idx       (idx1),
    .leak_prod (lprod1),
    .ctl       (ctl2),
    .sig       (sig2),
    .leaky     (leaky2)
  );

  nau_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl2),
    .sig_in   (sig2),
    .leaky_in (leaky2),
    .ctl      (ctl3),
    .sig      (sig3),
    .leaky    (leaky3),
    .prod     (prod3)
  );

  nau_final u_final (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl3),
    .sig_in     (sig3),
    .leaky_in   (leaky3),
    .prod_in    (prod3),
    .leak_slope (leak_slope),
    .done       (done),
    .y_value    (y_value)
  );

  // every request yields a result at the end of the pipeline
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 done)
    else $error("request did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##4 !done)
    else $error("result without a request");

  // clip output stays within [-1, 1]
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    (start && opcode == nau_pkg::OP_CLIP) |-> ##4
      ((y_value <= nau_pkg::DATA_W'(nau_pkg::ONE_WIDE)) &&
       (y_value >= -nau_pkg::DATA_W'(nau_pkg::ONE_WIDE))))
    else $error("clip result out of range");

  // derivative of identity is one
  a_did_one: assert property (@(posedge clk) disable iff (rst)
    (start && opcode == nau_pkg::OP_DID) |-> ##4
      (y_value == nau_pkg::DATA_W'(nau_pkg::ONE_WIDE)))
    else $error("identity derivative is not one");

endmodule

>>> design/nau_front.sv
// Stage 1: table index for the sigmoid argument and the leaky relu product.
// Depends on nau_pkg.

module nau_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [3:0]                             opcode,
  input  logic signed [nau_pkg::DATA_W-1:0]      x_value,
  input  logic [nau_pkg::LEAK_W-1:0]             leak_slope,
  output nau_pkg::nau_ctl_t                      ctl,
  output logic [nau_pkg::SIG_IDX_W-1:0]          idx,
  output logic signed [nau_pkg::LEAK_PROD_W-1:0] leak_prod
);

  nau_pkg::op_t                                op_in;
  logic signed [nau_pkg::VARG_W-1:0]           varg;
  logic signed [nau_pkg::VARG_W-1:0]           off;
  logic [nau_pkg::OFF_W+nau_pkg::SIG_IDX_W-1:0] scaled;
  logic [nau_pkg::SIG_IDX_W-1:0]               idx_next;
  logic signed [nau_pkg::LEAK_PROD_W-1:0]      leak_prod_next;

  // tanh and its derivative look up s(2x)
  always_comb begin
    op_in = nau_pkg::op_t'(opcode);
    if (op_in == nau_pkg::OP_TANH || op_in == nau_pkg::OP_DTANH) begin
      varg = {x_value, 1'b0};
    end else begin
      varg = {x_value[nau_pkg::DATA_W-1], x_value};
    end
  end

  // floor((v + 8) * N / 16) with the index held at the table ends
  always_comb begin
    off    = varg - nau_pkg::SIG_LO;
    scaled = nau_pkg::OFF_W'(off) *
             (nau_pkg::OFF_W + nau_pkg::SIG_IDX_W)'(nau_pkg::SIG_ENTRIES);
    if (varg < nau_pkg::SIG_LO) begin
      idx_next = '0;
    end else if (varg >= nau_pkg::SIG_HI) begin
      idx_next = nau_pkg::SIG_IDX_W'(nau_pkg::SIG_ENTRIES - 1);
    end else begin
      idx_next = scaled[nau_pkg::OFF_W +: nau_pkg::SIG_IDX_W];
    end
  end

  // x times the unsigned slope
  assign leak_prod_next = x_value * $signed({1'b0, leak_slope});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= start;
    end
    ctl.op    <= op_in;
    ctl.x     <= x_value;
    idx       <= idx_next;
    leak_prod <= leak_prod_next;
  end

endmodule

>>> design/nau_lookup.sv
// Stage 2: sigmoid table read and rounding of the leaky relu product.
// Depends on nau_pkg (table constant and types).

module nau_lookup (
  input  logic                                   clk,
  input  logic                                   rst,
  input  nau_pkg::nau_ctl_t                      ctl_in,
  input  logic [nau_pkg::SIG_IDX_W-1:0]          idx,
  input  logic signed [nau_pkg::LEAK_PROD_W-1:0] leak_prod,
  output nau_pkg::nau_ctl_t                      ctl,
  output logic [nau_pkg::SIG_W-1:0]              sig,
  output logic signed [nau_pkg::VARG_W-1:0]      leaky
);

  localparam logic signed [nau_pkg::LEAK_PROD_W-1:0] LEAK_HALF =
    nau_pkg::LEAK_PROD_W'(1 << (nau_pkg::LEAK_W - 1));

  logic signed [nau_pkg::LEAK_PROD_W-1:0] leak_sum;
  logic signed [nau_pkg::LEAK_PROD_W-1:0] leak_shift;

  // round half up: add half, then floor
  always_comb begin
    leak_sum   = leak_prod + LEAK_HALF;
    leak_shift = leak_sum >>> nau_pkg::LEAK_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_in.valid;
    end
    ctl.op <= ctl_in.op;
    ctl.x  <= ctl_in.x;
    sig    <= nau_pkg::SIG_TABLE[idx];
    leaky  <= leak_shift[nau_pkg::VARG_W-1:0];
  end

endmodule

>>> design/nau_mult.sv
// Stage 3: the one multiplier, s*(1-s) for the derivatives or t*t for 1-tanh^2.
// Depends on nau_pkg.

module nau_mult (
  input  logic                              clk,
  input  logic                              rst,
  input  nau_pkg::nau_ctl_t                 ctl_in,
  input  logic [nau_pkg::SIG_W-1:0]         sig_in,
  input  logic signed [nau_pkg::VARG_W-1:0] leaky_in,
  output nau_pkg::nau_ctl_t                 ctl,
  output logic [nau_pkg::SIG_W-1:0]         sig,
  output logic signed [nau_pkg::VARG_W-1:0] leaky,
  output logic signed [nau_pkg::PROD_W-1:0] prod
);

  localparam logic signed [nau_pkg::MUL_W-1:0] ONE_MUL =
    nau_pkg::MUL_W'(1 << nau_pkg::FRACTION_BITS);

  logic signed [nau_pkg::MUL_W-1:0] s_m;
  logic signed [nau_pkg::MUL_W-1:0] t_m;
  logic signed [nau_pkg::MUL_W-1:0] opa;
  logic signed [nau_pkg::MUL_W-1:0] opb;

  // operand select
  always_comb begin
    s_m = $signed({1'b0, sig_in});
    t_m = $signed({sig_in, 1'b0}) - ONE_MUL;
    if (ctl_in.op == nau_pkg::OP_DTANH) begin
      opa = t_m;
      opb = t_m;
    end else begin
      opa = s_m;
      opb = ONE_MUL - s_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_in.valid;
    end
    ctl.op <= ctl_in.op;
    ctl.x  <= ctl_in.x;
    sig    <= sig_in;
    leaky  <= leaky_in;
    prod   <= opa * opb;
  end

endmodule

>>> design/nau_final.sv
// Stage 4: result select per opcode, saturation and the output register.
// Depends on nau_pkg.

module nau_final (
  input  logic                              clk,
  input  logic                              rst,
  input  nau_pkg::nau_ctl_t                 ctl_in,
  input  logic [nau_pkg::SIG_W-1:0]         sig_in,
  input  logic signed [nau_pkg::VARG_W-1:0] leaky_in,
  input  logic signed [nau_pkg::PROD_W-1:0] prod_in,
  input  logic [nau_pkg::LEAK_W-1:0]        leak_slope,
  output logic                              done,
  output logic signed [nau_pkg::DATA_W-1:0] y_value
);

  localparam logic signed [nau_pkg::PROD_W-1:0] PROD_HALF =
    nau_pkg::PROD_W'(1 << (nau_pkg::FRACTION_BITS - 1));
  localparam logic [nau_pkg::LEAK_W+nau_pkg::FRACTION_BITS:0] DL_HALF =
    (nau_pkg::LEAK_W + nau_pkg::FRACTION_BITS + 1)'(1 << (nau_pkg::LEAK_W - 1));

  logic signed [nau_pkg::PROD_W-1:0]         prod_sum;
  logic signed [nau_pkg::PROD_W-1:0]         prod_rnd;
  logic signed [nau_pkg::WIDE_W-1:0]         r_w;
  logic signed [nau_pkg::WIDE_W-1:0]         s_w;
  logic signed [nau_pkg::WIDE_W-1:0]         x_w;
  logic signed [nau_pkg::WIDE_W-1:0]         lk_w;
  logic signed [nau_pkg::WIDE_W-1:0]         dl_w;
  logic [nau_pkg::LEAK_W+nau_pkg::FRACTION_BITS:0] dl_sum;
  logic signed [nau_pkg::WIDE_W-1:0]         y_wide;
  logic signed [nau_pkg::DATA_W-1:0]         y_next;

  // rounded product and operands at the common width
  always_comb begin
    prod_sum = prod_in + PROD_HALF;
    prod_rnd = prod_sum >>> nau_pkg::FRACTION_BITS;
    r_w      = nau_pkg::WIDE_W'(prod_rnd);
    s_w      = $signed({{(nau_pkg::WIDE_W - nau_pkg::SIG_W){1'b0}}, sig_in});
    x_w      = nau_pkg::WIDE_W'(ctl_in.x);
    lk_w     = nau_pkg::WIDE_W'(leaky_in);
    // leaky derivative: round(slope * ONE / 2^16)
    dl_sum   = {1'b0, leak_slope, {nau_pkg::FRACTION_BITS{1'b0}}} + DL_HALF;
    dl_w     = $signed({{(nau_pkg::WIDE_W - nau_pkg::FRACTION_BITS - 1){1'b0}},
                        dl_sum[nau_pkg::LEAK_W+nau_pkg::FRACTION_BITS:nau_pkg::LEAK_W]});
  end

  // per-opcode result
  always_comb begin
    case (ctl_in.op)
      nau_pkg::OP_SIG:    y_wide = s_w;
      nau_pkg::OP_DSIG:   y_wide = r_w;
      nau_pkg::OP_G:      y_wide = (s_w <<< 2) - (nau_pkg::ONE_WIDE <<< 1);
      nau_pkg::OP_DG:     y_wide = r_w <<< 2;
      nau_pkg::OP_H:      y_wide = (s_w <<< 1) - nau_pkg::ONE_WIDE;
      nau_pkg::OP_DH:     y_wide = r_w <<< 1;
      nau_pkg::OP_ID:     y_wide = x_w;
      nau_pkg::OP_DID:    y_wide = nau_pkg::ONE_WIDE;
      nau_pkg::OP_RELU:   y_wide = (x_w > 0) ? x_w : '0;
      nau_pkg::OP_DRELU:  y_wide = (x_w > 0) ? nau_pkg::ONE_WIDE : '0;
      nau_pkg::OP_LEAKY:  y_wide = (x_w > 0) ? x_w : lk_w;
      nau_pkg::OP_DLEAKY: y_wide = (x_w > 0) ? nau_pkg::ONE_WIDE : dl_w;
      nau_pkg::OP_TANH:   y_wide = (s_w <<< 1) - nau_pkg::ONE_WIDE;
      nau_pkg::OP_DTANH:  y_wide = nau_pkg::ONE_WIDE - r_w;
      nau_pkg::OP_CLIP: begin
        if (x_w > nau_pkg::ONE_WIDE) y_wide = nau_pkg::ONE_WIDE;
        else if (x_w < -nau_pkg::ONE_WIDE) y_wide = -nau_pkg::ONE_WIDE;
        else y_wide = x_w;
      end
      default:            y_wide = '0;
    endcase
  end

  // saturate to the output range
  always_comb begin
    if (y_wide > nau_pkg::Y_MAX) y_next = nau_pkg::DATA_W'(nau_pkg::Y_MAX);
    else if (y_wide < nau_pkg::Y_MIN) y_next = nau_pkg::DATA_W'(nau_pkg::Y_MIN);
    else y_next = y_wide[nau_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    y_value <= y_next;
  end

endmodule
